@@ rtl/assert_macros.svh @@
// Assertion macros used by the top-level RTL file of the odometry block.
// No dependencies; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ rtl/devo_pkg.sv @@
// Shared types, constants and helpers of the dual encoder odometry block.
// No dependencies; imported by every module of the block.
package devo_pkg;

    localparam int MODE_W  = 3;
    localparam int USER_W  = 4;
    localparam int DATA_W  = 40;
    localparam int OUT_W   = 240;
    localparam int CFG_AW  = 2;
    localparam int CFG_DW  = 32;
    localparam int STALE_W = 8;
    localparam int NUM_W   = 48;
    localparam int DEN_W   = 25;

    localparam logic [31:0]        SCALE_RESET = 32'd65536;
    localparam logic [15:0]        CPC_RESET   = 16'd2000;
    localparam logic [STALE_W-1:0] LIMIT_RESET = 8'd10;

    localparam logic [31:0] SPEED_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] SPEED_MIN = 32'h8000_0000;

    typedef enum logic [MODE_W-1:0] {
        MODE_PULSE     = 3'd0,
        MODE_TICK      = 3'd1,
        MODE_CLR_PART  = 3'd2,
        MODE_CLR_TOTAL = 3'd3,
        MODE_SUB       = 3'd4,
        MODE_SET_DIR   = 3'd5
    } t_mode;

    typedef enum logic [CFG_AW-1:0] {
        REG_SCALE = 2'd0,
        REG_CPC   = 2'd1,
        REG_LIMIT = 2'd2
    } t_reg;

    typedef struct packed {
        logic load_in;
        logic apply;
        logic wsel;
        logic idle_bump;
        logic mul;
        logic den;
        logic div_start;
        logic fix;
        logic bump;
        logic commit;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic partial_zero;
        logic mismatch;
        logic div_done;
    } t_dp_stat;

    function automatic logic [STALE_W-1:0] sat_inc(input logic [STALE_W-1:0] v);
        return (v == {STALE_W{1'b1}}) ? v : v + STALE_W'(1);
    endfunction

endpackage

@@ rtl/devo_div.sv @@
// Bit-serial restoring divider: one quotient bit per cycle, unsigned operands.
// Depends on devo_pkg for the operand widths.
module devo_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [devo_pkg::NUM_W-1:0]  i_dividend,
    input  logic [devo_pkg::DEN_W-1:0]  i_divisor,
    output logic                        o_done,
    output logic [devo_pkg::NUM_W-1:0]  o_quot
);
    import devo_pkg::*;

    localparam int CNT_W = $clog2(NUM_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NUM_W - 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [NUM_W-1:0] r_quo;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_dsr;

    logic [DEN_W:0]   w_shift;
    logic [DEN_W:0]   w_diff;
    logic             w_ge;

    assign w_shift = {r_rem, r_quo[NUM_W-1]};
    assign w_diff  = w_shift - {1'b0, r_dsr};
    assign w_ge    = !w_diff[DEN_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dsr <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[NUM_W-2:0], w_ge};
            r_rem <= w_ge ? w_diff[DEN_W-1:0] : w_shift[DEN_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule

@@ rtl/devo_datapath.sv @@
// Datapath: configuration, per-wheel counters, velocity estimate and result word.
// Depends on devo_pkg and devo_div.
module devo_datapath (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [devo_pkg::CFG_AW-1:0]  i_cfg_addr,
    input  logic [devo_pkg::CFG_DW-1:0]  i_cfg_wdata,
    input  logic [devo_pkg::USER_W-1:0]  i_user,
    input  logic [devo_pkg::DATA_W-1:0]  i_data,
    input  devo_pkg::t_dp_cmd            i_cmd,
    output devo_pkg::t_dp_stat           o_stat,
    output logic [devo_pkg::OUT_W-1:0]   o_data
);
    import devo_pkg::*;

    logic [31:0]        r_scale;
    logic [15:0]        r_cpc;
    logic [STALE_W-1:0] r_limit;

    logic [MODE_W-1:0]  r_mode;
    logic               r_wheel;
    logic [15:0]        r_stamp;
    logic               r_fwd_l;
    logic               r_fwd_r;
    logic [15:0]        r_steps;

    logic [15:0]        r_partial [2];
    logic [31:0]        r_total   [2];
    logic [31:0]        r_aux     [2];
    logic [STALE_W-1:0] r_stale   [2];
    logic [15:0]        r_last    [2];
    logic [15:0]        r_prev    [2];
    logic [31:0]        r_speed   [2];
    logic               r_dir     [2];

    logic [NUM_W-1:0]   r_nmag;
    logic               r_nneg;
    logic [DEN_W-1:0]   r_dprod;
    logic [DEN_W-1:0]   r_dmag;
    logic               r_qneg;
    logic [31:0]        r_est;
    logic [OUT_W-1:0]   r_out;

    logic               w_sel;
    logic [15:0]        w_part;
    logic [15:0]        w_pmag;
    logic [STALE_W-1:0] w_stale_inc;
    logic [STALE_W:0]   w_stale_p1;
    logic [DEN_W:0]     w_den;
    logic [DEN_W:0]     w_den_abs;
    logic [15:0]        w_step16;
    logic [31:0]        w_step32;
    logic [32:0]        w_sum;
    logic [32:0]        w_sum_adj;
    logic               w_div_done;
    logic [NUM_W-1:0]   w_quot;
    logic [31:0]        w_fix;

    assign w_sel       = i_cmd.wsel;
    assign w_part      = r_partial[w_sel];
    assign w_pmag      = w_part[15] ? 16'(-w_part) : w_part;
    assign w_stale_inc = sat_inc(r_stale[w_sel]);
    assign w_stale_p1  = {1'b0, r_stale[w_sel]} + (STALE_W+1)'(1);
    assign w_den       = {1'b0, r_dprod} + {10'b0, r_last[w_sel]} - {10'b0, r_prev[w_sel]};
    assign w_den_abs   = w_den[DEN_W] ? (DEN_W+1)'(-w_den) : w_den;
    assign w_step16    = r_dir[r_wheel] ? 16'h0001 : 16'hFFFF;
    assign w_step32    = {{16{w_step16[15]}}, w_step16};
    assign w_sum       = {r_total[0][31], r_total[0]} + {r_total[1][31], r_total[1]};
    assign w_sum_adj   = w_sum + {32'b0, w_sum[32]};

    devo_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_nmag),
        .i_divisor  (r_dmag),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    always_comb begin
        if (r_dmag == '0) begin
            if (r_nmag == '0) begin
                w_fix = '0;
            end else begin
                w_fix = r_nneg ? SPEED_MIN : SPEED_MAX;
            end
        end else if (r_qneg) begin
            if ((w_quot[NUM_W-1:32] != '0) || (w_quot[31] && (w_quot[30:0] != '0))) begin
                w_fix = SPEED_MIN;
            end else begin
                w_fix = 32'(-w_quot[31:0]);
            end
        end else begin
            w_fix = (w_quot[NUM_W-1:31] != '0) ? SPEED_MAX : w_quot[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale <= SCALE_RESET;
            r_cpc   <= CPC_RESET;
            r_limit <= LIMIT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_SCALE: r_scale <= i_cfg_wdata;
                REG_CPC:   r_cpc   <= i_cfg_wdata[15:0];
                REG_LIMIT: r_limit <= i_cfg_wdata[STALE_W-1:0];
                default:   ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_mode  <= i_user[MODE_W-1:0];
            r_wheel <= i_user[MODE_W];
            r_stamp <= i_data[15:0];
            r_fwd_l <= i_data[16];
            r_fwd_r <= i_data[17];
            r_steps <= i_data[33:18];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 2; i++) begin
                r_partial[i] <= '0;
                r_total[i]   <= '0;
                r_aux[i]     <= '0;
                r_stale[i]   <= '0;
                r_last[i]    <= '0;
                r_prev[i]    <= '0;
                r_speed[i]   <= '0;
                r_dir[i]     <= 1'b1;
            end
        end else begin
            if (i_cmd.apply) begin
                unique case (r_mode)
                    MODE_PULSE: begin
                        r_last[r_wheel]    <= r_stamp;
                        r_partial[r_wheel] <= r_partial[r_wheel] + w_step16;
                        r_total[r_wheel]   <= r_total[r_wheel] + w_step32;
                        r_aux[r_wheel]     <= r_aux[r_wheel] + w_step32;
                    end
                    MODE_CLR_PART: begin
                        r_partial[0] <= '0;
                        r_partial[1] <= '0;
                    end
                    MODE_CLR_TOTAL: begin
                        r_total[0] <= '0;
                        r_total[1] <= '0;
                    end
                    MODE_SUB: begin
                        r_total[0] <= r_total[0] - {{16{r_steps[15]}}, r_steps};
                        r_total[1] <= r_total[1] - {{16{r_steps[15]}}, r_steps};
                    end
                    MODE_SET_DIR: begin
                        r_dir[0] <= r_fwd_l;
                        r_dir[1] <= r_fwd_r;
                    end
                    default: ;
                endcase
            end
            if (i_cmd.idle_bump) begin
                r_stale[w_sel] <= w_stale_inc;
                if (w_stale_inc >= r_limit) begin
                    r_speed[w_sel] <= '0;
                end
            end
            if (i_cmd.bump) begin
                r_stale[w_sel] <= w_stale_inc;
            end
            if (i_cmd.commit) begin
                r_speed[w_sel] <= r_est;
                r_stale[w_sel] <= '0;
                r_prev[w_sel]  <= r_last[w_sel];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_nmag  <= {16'b0, r_scale} * {32'b0, w_pmag};
            r_nneg  <= w_part[15];
            r_dprod <= {9'b0, r_cpc} * {16'b0, w_stale_p1};
        end
        if (i_cmd.den) begin
            r_dmag <= w_den_abs[DEN_W-1:0];
            r_qneg <= r_nneg ^ w_den[DEN_W];
        end
        if (i_cmd.fix) begin
            r_est <= w_fix;
        end
        if (i_cmd.load_out) begin
            r_out <= {r_stale[1], r_stale[0], w_sum_adj[32:1], r_aux[1], r_aux[0],
                      r_total[1], r_total[0], r_speed[1], r_speed[0]};
        end
    end

    assign o_stat.partial_zero = (w_part == '0);
    assign o_stat.mismatch     = (r_est[31] && r_dir[w_sel])
                              || (!r_est[31] && (r_est != '0) && !r_dir[w_sel]);
    assign o_stat.div_done     = w_div_done;
    assign o_data              = r_out;

endmodule

@@ rtl/devo_ctrl.sv @@
// Controller: sequences item handling, the per-wheel estimate and the result handshake.
// Depends on devo_pkg; drives the datapath through t_dp_cmd.
module devo_ctrl (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_s_axis_tvalid,
    output logic                         o_s_axis_tready,
    input  logic [devo_pkg::MODE_W-1:0]  i_mode,
    output logic                         o_m_axis_tvalid,
    input  logic                         i_m_axis_tready,
    input  devo_pkg::t_dp_stat           i_stat,
    output devo_pkg::t_dp_cmd            o_cmd
);
    import devo_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_APPLY,
        S_TCHK,
        S_MUL,
        S_DEN,
        S_DIV,
        S_WAIT,
        S_FIX,
        S_JUDGE,
        S_OUT
    } t_state;

    t_state  r_state;
    t_state  n_state;
    logic    r_wheel;
    logic    n_wheel;
    logic    r_retry;
    logic    n_retry;
    logic    r_out_valid;
    logic    n_out_valid;
    t_dp_cmd w_cmd;

    always_comb begin
        w_cmd       = '0;
        w_cmd.wsel  = r_wheel;
        n_state     = r_state;
        n_wheel     = r_wheel;
        n_retry     = r_retry;
        n_out_valid = r_out_valid && !i_m_axis_tready;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_axis_tvalid) begin
                    w_cmd.load_in = 1'b1;
                    n_wheel       = 1'b0;
                    n_retry       = 1'b0;
                    n_state       = (i_mode == MODE_TICK) ? S_TCHK : S_APPLY;
                end
            end
            S_APPLY: begin
                w_cmd.apply = 1'b1;
                n_state     = S_OUT;
            end
            S_TCHK: begin
                if (i_stat.partial_zero) begin
                    w_cmd.idle_bump = 1'b1;
                    n_wheel         = 1'b1;
                    n_state         = r_wheel ? S_OUT : S_TCHK;
                end else begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                w_cmd.mul = 1'b1;
                n_state   = S_DEN;
            end
            S_DEN: begin
                w_cmd.den = 1'b1;
                n_state   = S_DIV;
            end
            S_DIV: begin
                w_cmd.div_start = 1'b1;
                n_state         = S_WAIT;
            end
            S_WAIT: begin
                if (i_stat.div_done) begin
                    n_state = S_FIX;
                end
            end
            S_FIX: begin
                w_cmd.fix = 1'b1;
                n_state   = S_JUDGE;
            end
            S_JUDGE: begin
                if (i_stat.mismatch && !r_retry) begin
                    w_cmd.bump = 1'b1;
                    n_retry    = 1'b1;
                    n_state    = S_MUL;
                end else begin
                    w_cmd.commit = 1'b1;
                    n_retry      = 1'b0;
                    n_wheel      = 1'b1;
                    n_state      = r_wheel ? S_OUT : S_TCHK;
                end
            end
            S_OUT: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    w_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wheel     <= 1'b0;
            r_retry     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_wheel     <= n_wheel;
            r_retry     <= n_retry;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_cmd           = w_cmd;

endmodule

@@ rtl/dual_encoder_odometry_velocity_top.sv @@
// Top level of the dual encoder odometry block: controller, datapath and checks.
// Depends on devo_pkg, devo_ctrl, devo_datapath and assert_macros.svh.
//
// Input stream: one word per event. tuser selects the operation (pulse, control
// tick, clear partial, clear total, subtract steps, set directions) and the wheel.
// Output stream: one word per input word with both velocities, totals,
// auxiliary counters, the mean distance and both idle tick counts.
// Configuration: write velocity_scale, counts_per_cycle or stale_limit by index
// while no word is in flight.
// Sequence: a non-tick word is applied, then output. A tick takes each wheel in
// turn: an idle wheel bumps its idle count, another runs multiply, denominator,
// the shared bit-serial divider, fix and judge, and again on a direction mismatch.
// One word is processed at a time; the next is taken once the current result is
// parked in the output register, so a stalled receiver holds one finished word
// and blocks only the completion of the following one.
// Reset: counters, stamps and velocities clear, both directions go forward,
// configuration returns to 65536, 2000 and 10.
`include "assert_macros.svh"

module dual_encoder_odometry_velocity_top (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [devo_pkg::CFG_AW-1:0]  i_cfg_addr,
    input  logic [devo_pkg::CFG_DW-1:0]  i_cfg_wdata,
    input  logic                         i_s_axis_tvalid,
    output logic                         o_s_axis_tready,
    // timestamp[15:0], forward_left[16], forward_right[17], steps[33:18], zero[39:34]
    input  logic [devo_pkg::DATA_W-1:0]  i_s_axis_tdata,
    // mode[2:0], wheel[3]
    input  logic [devo_pkg::USER_W-1:0]  i_s_axis_tuser,
    output logic                         o_m_axis_tvalid,
    input  logic                         i_m_axis_tready,
    // speed_left[31:0], speed_right[63:32], distance_left[95:64],
    // distance_right[127:96], extra_left[159:128], extra_right[191:160],
    // mean_distance[223:192], idle_left[231:224], idle_right[239:232]
    output logic [devo_pkg::OUT_W-1:0]   o_m_axis_tdata
);
    import devo_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    devo_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_mode          (i_s_axis_tuser[MODE_W-1:0]),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .i_stat          (w_stat),
        .o_cmd           (w_cmd)
    );

    devo_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_user      (i_s_axis_tuser),
        .i_data      (i_s_axis_tdata),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .o_data      (o_m_axis_tdata)
    );

    `ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_s_axis_tvalid && o_s_axis_tready, !o_s_axis_tready)
    `ASSERT_IMPLIES(a_no_result_overwrite, i_clk, i_rst_n, w_cmd.load_out, !o_m_axis_tvalid || i_m_axis_tready)
    `ASSERT_NEXT(a_div_not_instant, i_clk, i_rst_n, w_cmd.div_start, !w_stat.div_done)

endmodule

@@ test/tb_dual_encoder_odometry_velocity_top.sv @@
// Self-checking testbench of the dual encoder odometry block: pulses, control ticks,
// counter clears, step subtraction and direction changes under random stream stalls.
// Depends on devo_pkg and dual_encoder_odometry_velocity_top.
`timescale 1ns / 1ps

module tb_dual_encoder_odometry_velocity_top;
    import devo_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int TAIL_CYCLES = 250;
    localparam logic [2:0] MODE_SPARE_A = 3'd6;
    localparam logic [2:0] MODE_SPARE_B = 3'd7;

    typedef struct {
        logic [2:0]         mode;
        logic               wheel;
        logic [15:0]        stamp;
        logic               fwd_l;
        logic               fwd_r;
        logic signed [15:0] steps;
    } t_odo_word;

    typedef struct packed {
        logic [7:0]  idle_right;
        logic [7:0]  idle_left;
        logic [31:0] mean_distance;
        logic [31:0] extra_right;
        logic [31:0] extra_left;
        logic [31:0] distance_right;
        logic [31:0] distance_left;
        logic [31:0] speed_right;
        logic [31:0] speed_left;
    } t_odo_report;

    class odometry_tracker;
        logic [31:0]        scale;
        logic [15:0]        cpc;
        logic [7:0]         limit;
        logic [15:0]        partial [2];
        logic [31:0]        total [2];
        logic [31:0]        aux [2];
        logic [7:0]         stale [2];
        logic [15:0]        last_ts [2];
        logic [15:0]        prev_ts [2];
        logic signed [31:0] vel [2];
        bit                 fwd [2];
        t_odo_report        expected_reports [$];
        int                 mismatches;
        int                 accepted;
        int                 checked;

        function new();
            scale = SCALE_RESET;
            cpc = CPC_RESET;
            limit = LIMIT_RESET;
            for (int w = 0; w < 2; w++) begin
                partial[w] = '0;
                total[w] = '0;
                aux[w] = '0;
                stale[w] = '0;
                last_ts[w] = '0;
                prev_ts[w] = '0;
                vel[w] = '0;
                fwd[w] = 1'b1;
            end
            mismatches = 0;
            accepted = 0;
            checked = 0;
        endfunction

        function void write_reg(t_reg idx, logic [31:0] val);
            case (idx)
                REG_SCALE: scale = val;
                REG_CPC:   cpc = val[15:0];
                REG_LIMIT: limit = val[7:0];
                default: ;
            endcase
        endfunction

        function logic signed [31:0] wheel_velocity(int w);
            longint num, den, q;
            num = longint'(scale) * longint'($signed(partial[w]));
            den = longint'(cpc) * (longint'(stale[w]) + 1)
                + longint'(last_ts[w]) - longint'(prev_ts[w]);
            if (den == 0) begin
                if (num > 0) return SPEED_MAX;
                if (num < 0) return SPEED_MIN;
                return '0;
            end
            q = num / den;
            if (q > longint'(32'sh7FFF_FFFF)) return SPEED_MAX;
            if (q < -longint'(32'sh7FFF_FFFF) - 1) return SPEED_MIN;
            return q[31:0];
        endfunction

        function void control_tick(int w);
            logic signed [31:0] v;
            if (partial[w] == '0) begin
                if (stale[w] != 8'hFF) stale[w]++;
                if (stale[w] >= limit) vel[w] = '0;
                return;
            end
            v = wheel_velocity(w);
            if ((v < 0 && fwd[w]) || (v > 0 && !fwd[w])) begin
                if (stale[w] != 8'hFF) stale[w]++;
                v = wheel_velocity(w);
            end
            vel[w] = v;
            stale[w] = '0;
            prev_ts[w] = last_ts[w];
        endfunction

        function void note_word(t_odo_word wd);
            t_odo_report r;
            longint mean;
            int w;
            w = wd.wheel;
            case (wd.mode)
                MODE_PULSE: begin
                    last_ts[w] = wd.stamp;
                    if (fwd[w]) begin
                        partial[w]++;
                        total[w]++;
                        aux[w]++;
                    end else begin
                        partial[w]--;
                        total[w]--;
                        aux[w]--;
                    end
                end
                MODE_TICK: begin
                    control_tick(0);
                    control_tick(1);
                end
                MODE_CLR_PART: begin
                    partial[0] = '0;
                    partial[1] = '0;
                end
                MODE_CLR_TOTAL: begin
                    total[0] = '0;
                    total[1] = '0;
                end
                MODE_SUB: begin
                    total[0] -= {{16{wd.steps[15]}}, wd.steps};
                    total[1] -= {{16{wd.steps[15]}}, wd.steps};
                end
                MODE_SET_DIR: begin
                    fwd[0] = wd.fwd_l;
                    fwd[1] = wd.fwd_r;
                end
                default: ;
            endcase
            mean = (longint'($signed(total[0])) + longint'($signed(total[1]))) / 2;
            r.speed_left = vel[0];
            r.speed_right = vel[1];
            r.distance_left = total[0];
            r.distance_right = total[1];
            r.extra_left = aux[0];
            r.extra_right = aux[1];
            r.mean_distance = mean[31:0];
            r.idle_left = stale[0];
            r.idle_right = stale[1];
            expected_reports.push_back(r);
            accepted++;
        endfunction

        function bit field_differs(string label, logic [31:0] exp_v, logic [31:0] got_v);
            if (got_v === exp_v) return 1'b0;
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch on word %0d, %s: expected %h, got %h",
                         checked, label, exp_v, got_v);
            return 1'b1;
        endfunction

        function void check_word(logic [OUT_W-1:0] data);
            t_odo_report e, g;
            bit bad;
            g = t_odo_report'(data);
            if (expected_reports.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("result word %h with no input pending", data);
                return;
            end
            e = expected_reports.pop_front();
            bad = field_differs("speed_left", e.speed_left, g.speed_left);
            bad |= field_differs("speed_right", e.speed_right, g.speed_right);
            bad |= field_differs("distance_left", e.distance_left, g.distance_left);
            bad |= field_differs("distance_right", e.distance_right, g.distance_right);
            bad |= field_differs("extra_left", e.extra_left, g.extra_left);
            bad |= field_differs("extra_right", e.extra_right, g.extra_right);
            bad |= field_differs("mean_distance", e.mean_distance, g.mean_distance);
            bad |= field_differs("idle_left", 32'(e.idle_left), 32'(g.idle_left));
            bad |= field_differs("idle_right", 32'(e.idle_right), 32'(g.idle_right));
            checked++;
        endfunction

        function int pending();
            return expected_reports.size();
        endfunction
    endclass

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic [CFG_AW-1:0]   i_cfg_addr;
    logic [CFG_DW-1:0]   i_cfg_wdata;
    logic                i_s_axis_tvalid;
    logic                o_s_axis_tready;
    logic [DATA_W-1:0]   i_s_axis_tdata;
    logic [USER_W-1:0]   i_s_axis_tuser;
    logic                o_m_axis_tvalid;
    logic                i_m_axis_tready;
    logic [OUT_W-1:0]    o_m_axis_tdata;

    odometry_tracker tracker;
    bit              steady;
    logic [15:0]     stamp_now [2];
    int              cycles;
    int              settings_used;

    dual_encoder_odometry_velocity_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("timeout after %0d cycles", cycles);
        $display("[FAIL] regression broken");
        $finish;
    end

    // result side: stall at random, check every accepted word
    initial begin
        int stall;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            stall = steady ? 0 : $urandom_range(0, 12);
            if (stall > 0) begin
                i_m_axis_tready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_m_axis_tready = 1'b1;
            do @(posedge i_clk); while (!o_m_axis_tvalid);
            tracker.check_word(o_m_axis_tdata);
            @(negedge i_clk);
        end
    end

    function automatic t_odo_word make_word(logic [2:0] mode, logic wheel, logic [15:0] stamp,
                                            logic fl, logic fr, logic [15:0] steps);
        t_odo_word w;
        w.mode = mode;
        w.wheel = wheel;
        w.stamp = stamp;
        w.fwd_l = fl;
        w.fwd_r = fr;
        w.steps = steps;
        return w;
    endfunction

    function automatic t_odo_word rand_word(logic [2:0] mode);
        return make_word(mode, 1'($urandom), 16'($urandom), 1'($urandom), 1'($urandom),
                         16'($urandom));
    endfunction

    task automatic push_word(input t_odo_word w);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            i_s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_axis_tuser = {w.wheel, w.mode};
        i_s_axis_tdata = {6'd0, w.steps, w.fwd_r, w.fwd_l, w.stamp};
        i_s_axis_tvalid = 1'b1;
        do @(posedge i_clk); while (!o_s_axis_tready);
        tracker.note_word(w);
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_s_axis_tvalid = 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic configure(logic [31:0] scale, logic [15:0] cpc, logic [7:0] limit);
        t_reg idx [3];
        logic [31:0] val [3];
        idx = '{REG_SCALE, REG_CPC, REG_LIMIT};
        val = '{scale, 32'(cpc), 32'(limit)};
        for (int i = 0; i < 3; i++) begin
            i_cfg_we = 1'b1;
            i_cfg_addr = idx[i];
            i_cfg_wdata = val[i];
            tracker.write_reg(idx[i], val[i]);
            @(negedge i_clk);
        end
        i_cfg_we = 1'b0;
        settings_used++;
    endtask

    task automatic run_traffic(int n);
        int done, pick, reps;
        t_odo_word w;
        done = 0;
        while (done < n) begin
            if ($urandom_range(0, 15) == 0) steady = ~steady;
            pick = $urandom_range(0, 99);
            if (pick < 65) begin
                reps = $urandom_range(0, 6);
                for (int k = 0; k < reps; k++) begin
                    w = rand_word(MODE_PULSE);
                    stamp_now[w.wheel] += 16'($urandom_range(0, 3000));
                    w.stamp = stamp_now[w.wheel];
                    push_word(w);
                    done++;
                end
                push_word(rand_word(MODE_TICK));
                done++;
                if ($urandom_range(0, 1) == 1) begin
                    push_word(rand_word(MODE_CLR_PART));
                    done++;
                end
            end else if (pick < 75) begin
                push_word(rand_word(MODE_SET_DIR));
                done++;
            end else if (pick < 83) begin
                push_word(rand_word(MODE_SUB));
                done++;
            end else if (pick < 87) begin
                push_word(rand_word(MODE_CLR_TOTAL));
                done++;
            end else if (pick < 94) begin
                reps = $urandom_range(1, 12);
                for (int k = 0; k < reps; k++) push_word(rand_word(MODE_TICK));
                done += reps;
            end else begin
                push_word(rand_word(3'($urandom_range(0, 7))));
                done++;
            end
        end
    endtask

    initial begin
        tracker = new();
        steady = 1'b0;
        settings_used = 0;
        stamp_now[0] = '0;
        stamp_now[1] = '0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_addr = '0;
        i_cfg_wdata = '0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata = '0;
        i_s_axis_tuser = '0;
        i_m_axis_tready = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // idle tick, zero denominator both signs, direction retry, field extremes
        push_word(make_word(MODE_TICK, 1'b0, 16'd0, 1'b0, 1'b0, 16'd0));
        push_word(make_word(MODE_PULSE, 1'b0, 16'd5000, 1'b0, 1'b0, 16'd0));
        push_word(make_word(MODE_PULSE, 1'b1, 16'hFFFF, 1'b1, 1'b1, 16'hFFFF));
        push_word(make_word(MODE_TICK, 1'b1, 16'hFFFF, 1'b1, 1'b1, 16'hFFFF));
        push_word(make_word(MODE_PULSE, 1'b0, 16'd3000, 1'b0, 1'b0, 16'd0));
        push_word(make_word(MODE_TICK, 1'b0, 16'd0, 1'b0, 1'b0, 16'd0));
        push_word(make_word(MODE_SET_DIR, 1'b0, 16'd0, 1'b0, 1'b1, 16'd0));
        push_word(make_word(MODE_CLR_PART, 1'b1, 16'd0, 1'b0, 1'b0, 16'd0));
        push_word(make_word(MODE_PULSE, 1'b0, 16'd1000, 1'b0, 1'b0, 16'd0));
        push_word(make_word(MODE_TICK, 1'b0, 16'd0, 1'b0, 1'b0, 16'd0));
        push_word(make_word(MODE_PULSE, 1'b1, 16'd0, 1'b0, 1'b0, 16'd0));
        push_word(make_word(MODE_SET_DIR, 1'b0, 16'd0, 1'b1, 1'b0, 16'd0));
        push_word(make_word(MODE_TICK, 1'b0, 16'd0, 1'b0, 1'b0, 16'd0));
        push_word(make_word(MODE_SUB, 1'b0, 16'd0, 1'b0, 1'b0, 16'h8000));
        push_word(make_word(MODE_SUB, 1'b1, 16'd0, 1'b0, 1'b0, 16'h7FFF));
        push_word(make_word(MODE_CLR_TOTAL, 1'b0, 16'd0, 1'b0, 1'b0, 16'd0));
        push_word(make_word(MODE_SUB, 1'b0, 16'd0, 1'b0, 1'b0, 16'hFFFF));
        push_word(make_word(MODE_SPARE_A, 1'b1, 16'hFFFF, 1'b1, 1'b1, 16'hFFFF));
        push_word(make_word(MODE_SPARE_B, 1'b0, 16'h5A5A, 1'b0, 1'b1, 16'h1234));
        push_word(make_word(MODE_SET_DIR, 1'b1, 16'hFFFF, 1'b1, 1'b1, 16'hFFFF));
        push_word(make_word(MODE_PULSE, 1'b1, 16'hFFFF, 1'b1, 1'b1, 16'hFFFF));
        push_word(make_word(MODE_CLR_PART, 1'b0, 16'd0, 1'b0, 1'b0, 16'd0));
        push_word(make_word(MODE_TICK, 1'b0, 16'd0, 1'b0, 1'b0, 16'd0));
        push_word(make_word(MODE_TICK, 1'b1, 16'd0, 1'b0, 1'b0, 16'd0));
        run_traffic(20);

        drain();
        configure(32'hFFFF_FFFF, 16'd1, 8'd1);
        run_traffic(25);

        drain();
        configure(32'd0, 16'hFFFF, 8'hFF);
        run_traffic(20);

        // hold a nonzero speed through a long idle run until the idle count saturates
        drain();
        configure(32'h0003_2000, 16'hFFFF, 8'hFF);
        push_word(rand_word(MODE_PULSE));
        push_word(rand_word(MODE_TICK));
        push_word(rand_word(MODE_CLR_PART));
        steady = 1'b1;
        for (int k = 0; k < 260; k++) push_word(rand_word(MODE_TICK));
        steady = 1'b0;
        run_traffic(20);

        drain();
        configure(32'd65536, 16'd0, 8'd0);
        run_traffic(20);

        drain();
        configure($urandom, 16'($urandom_range(1, 65535)), 8'($urandom_range(1, 255)));
        run_traffic(25);

        drain();
        configure(32'd1, 16'd2000, 8'd10);
        run_traffic(20);

        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("sent %0d input words over %0d register settings, checked %0d results",
                 tracker.accepted, settings_used + 1, tracker.checked);
        $display("mismatches: %0d, results still owed: %0d",
                 tracker.mismatches, tracker.pending());
        if (tracker.mismatches == 0 && tracker.pending() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

@@ files.f @@
+incdir+rtl
rtl/devo_pkg.sv
rtl/devo_div.sv
rtl/devo_datapath.sv
rtl/devo_ctrl.sv
rtl/dual_encoder_odometry_velocity_top.sv
test/tb_dual_encoder_odometry_velocity_top.sv
